// File: rtl/display_mode_fallback_search_defines.svh
// Assertion macros used by the verification code of the mode search block.
`ifndef DISPLAY_MODE_FALLBACK_SEARCH_DEFINES_SVH
`define DISPLAY_MODE_FALLBACK_SEARCH_DEFINES_SVH

// The consequent must hold at the clock edge after the antecedent.
`define DMFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("display mode search: next-cycle property failed");

// The consequent must hold at the same clock edge as the antecedent.
`define DMFS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("display mode search: same-cycle property failed");

`endif

// File: rtl/dmfs_pkg.sv
package dmfs_pkg;

  // Field widths of a mode entry, the table index, the registers and the APB port.
  localparam int unsigned WIDTH_W   = 16;
  localparam int unsigned HEIGHT_W  = 16;
  localparam int unsigned BPP_W     = 7;
  localparam int unsigned HZ_W      = 10;
  localparam int unsigned AREA_W    = WIDTH_W + HEIGHT_W;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 4;

  localparam int unsigned DEFAULT_TABLE_DEPTH = 64;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0] RESET_MIN_WIDTH      = 16'd640;
  localparam logic [CFG_W-1:0] RESET_MIN_HEIGHT     = 16'd480;
  localparam logic [CFG_W-1:0] RESET_EXCLUDED_WIDTH = 16'd960;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_MIN_WIDTH      = 2'd0;
  localparam logic [1:0] REG_MIN_HEIGHT     = 2'd1;
  localparam logic [1:0] REG_EXCLUDED_WIDTH = 2'd2;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_SMALLER_RES,
    KIND_LOWER_HZ,
    KIND_HIGHER_HZ
  } kind_e;

  typedef struct packed {
    logic [WIDTH_W-1:0]  width;
    logic [HEIGHT_W-1:0] height;
    logic [BPP_W-1:0]    pixel_bits;
    logic [HZ_W-1:0]     refresh_hz;
  } mode_t;

  typedef struct packed {
    kind_e               kind;
    logic [IDX_W-1:0]    entry_index;
    logic [WIDTH_W-1:0]  width;
    logic [HEIGHT_W-1:0] height;
    logic [BPP_W-1:0]    pixel_bits;
    logic [HZ_W-1:0]     refresh_hz;
  } in_item_t;

  typedef struct packed {
    logic                found;
    logic [WIDTH_W-1:0]  new_width;
    logic [HEIGHT_W-1:0] new_height;
    logic [BPP_W-1:0]    new_pixel_bits;
    logic [HZ_W-1:0]     new_refresh_hz;
  } out_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] min_width;
    logic [CFG_W-1:0] min_height;
    logic [CFG_W-1:0] excluded_width;
  } cfg_t;

  // Query token that walks the cell row, one cell per cycle unless the row holds.
  typedef struct packed {
    logic               valid;
    kind_e              kind;
    mode_t              cur;
    logic [AREA_W-1:0]  cur_area;
    logic               stop;
    logic               found;
    mode_t              best;
  } token_t;

  // Table write broadcast to every cell.
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  index;
    mode_t             entry;
    logic [AREA_W-1:0] area;
  } load_t;

endpackage

// File: rtl/dmfs_stream_if.sv
interface dmfs_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/dmfs_cfg_regs.sv
module dmfs_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dmfs_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [dmfs_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [dmfs_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output dmfs_pkg::cfg_t                      cfg_o
);
  import dmfs_pkg::*;

  cfg_t       cfg_q;
  cfg_t       cfg_d;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // Register write decode; writes beyond the list are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_MIN_WIDTH:      cfg_d.min_width      = pwdata[CFG_W-1:0];
        REG_MIN_HEIGHT:     cfg_d.min_height     = pwdata[CFG_W-1:0];
        REG_EXCLUDED_WIDTH: cfg_d.excluded_width = pwdata[CFG_W-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_width      <= RESET_MIN_WIDTH;
      cfg_q.min_height     <= RESET_MIN_HEIGHT;
      cfg_q.excluded_width <= RESET_EXCLUDED_WIDTH;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read mux; unused addresses read as zero.
  always_comb begin
    case (reg_idx)
      REG_MIN_WIDTH:      prdata = APB_DATA_W'(cfg_q.min_width);
      REG_MIN_HEIGHT:     prdata = APB_DATA_W'(cfg_q.min_height);
      REG_EXCLUDED_WIDTH: prdata = APB_DATA_W'(cfg_q.excluded_width);
      default:            prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/dmfs_cell.sv
module dmfs_cell #(
  parameter int unsigned CELL_INDEX = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dmfs_pkg::cfg_t   cfg_i,
  input  dmfs_pkg::load_t  load_i,
  input  logic             advance_i,
  input  dmfs_pkg::token_t tok_i,
  output dmfs_pkg::token_t tok_o
);
  import dmfs_pkg::*;

  mode_t             entry_q;
  logic [AREA_W-1:0] area_q;
  token_t            tok_q;
  token_t            tok_d;
  logic              hit;
  logic              empty;
  logic              live;
  logic              same_bpp;
  logic              same_res;
  logic              smaller_res;
  logic              res_ok;
  logic              lower_ok;
  logic              higher_ok;
  logic              take;

  // This cell owns one table slot; slots past the index range never match.
  assign hit = load_i.we && (CELL_INDEX < (1 << IDX_W)) &&
               (load_i.index == IDX_W'(CELL_INDEX));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
      area_q  <= '0;
    end else if (hit) begin
      entry_q <= load_i.entry;
      area_q  <= load_i.area;
    end
  end

  // Compare the held entry with the passing query.
  assign empty    = (entry_q.width == '0);
  assign live     = tok_i.valid && !tok_i.stop && !empty;
  assign same_bpp = (entry_q.pixel_bits == tok_i.cur.pixel_bits);
  assign same_res = (entry_q.width == tok_i.cur.width) &&
                    (entry_q.height == tok_i.cur.height);

  assign smaller_res = ((entry_q.width <= tok_i.cur.width) &&
                        (entry_q.height < tok_i.cur.height)) ||
                       ((entry_q.width < tok_i.cur.width) &&
                        (entry_q.height <= tok_i.cur.height)) ||
                       (area_q < tok_i.cur_area);

  assign res_ok = (entry_q.width >= cfg_i.min_width) &&
                  (entry_q.height >= cfg_i.min_height) &&
                  (entry_q.width != cfg_i.excluded_width) && smaller_res &&
                  (!tok_i.found || (tok_i.best.width < entry_q.width) ||
                   ((tok_i.best.width == entry_q.width) &&
                    (tok_i.best.height < entry_q.height)));

  assign lower_ok = same_res && (entry_q.refresh_hz < tok_i.cur.refresh_hz) &&
                    (tok_i.best.refresh_hz < entry_q.refresh_hz);

  assign higher_ok = same_res && (entry_q.refresh_hz > tok_i.cur.refresh_hz) &&
                     (!tok_i.found || (entry_q.refresh_hz < tok_i.best.refresh_hz));

  always_comb begin
    case (tok_i.kind)
      KIND_SMALLER_RES: take = res_ok;
      KIND_LOWER_HZ:    take = lower_ok;
      KIND_HIGHER_HZ:   take = higher_ok;
      default:          take = 1'b0;
    endcase
    take = take && live && same_bpp;
  end

  // Update the token; an empty slot ends the scan for all later cells.
  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid && empty) begin
      tok_d.stop = 1'b1;
    end
    if (take) begin
      tok_d.best  = entry_q;
      tok_d.found = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else if (advance_i) begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// File: rtl/display_mode_fallback_search.sv
// Display mode fallback search. The mode table lives in a row of TABLE_DEPTH
// cells, one entry per cell, all cleared to zero by reset with no clearing
// pass. A load transaction writes one cell and returns nothing; loads to a
// slot beyond the table are dropped. A query transaction is registered, then
// passes down the cell row one cell per cycle while the row is not held,
// each cell folding its entry into the running best choice. The input
// reopens in the same cycle as the query's result is presented, and no new
// transaction is taken during the walk. The result register lets the next
// transaction enter while an earlier result waits; a query that finishes
// while the previous result is still unread holds at the end of the row.
// Registers are to be written through the APB port only while the block is
// idle; the user is bound by this and the block itself does not enforce it.
module display_mode_fallback_search #(
  parameter int unsigned TABLE_DEPTH = dmfs_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  dmfs_stream_if.sink                     in_i,
  dmfs_stream_if.source                   out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dmfs_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [dmfs_pkg::APB_DATA_W-1:0] pwdata,
  output logic [dmfs_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import dmfs_pkg::*;

  cfg_t              cfg;
  in_item_t          item;
  logic              accept;
  logic              accept_query;
  logic [AREA_W-1:0] item_area;
  load_t             load;
  token_t            launch_q;
  token_t            launch_d;
  token_t            tok [TABLE_DEPTH+1];
  token_t            tail;
  logic              advance;
  logic              drain;
  logic              busy_q;
  logic              busy_d;
  logic              out_valid_q;
  logic              out_valid_d;
  out_item_t         out_q;
  out_item_t         out_d;

  dmfs_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Input side: one transaction at a time while a query walks the row.
  assign item         = in_i.payload;
  assign in_i.ready   = !busy_q;
  assign accept       = in_i.valid && !busy_q;
  assign accept_query = accept && (item.kind != KIND_LOAD);
  assign item_area    = AREA_W'(item.width) * AREA_W'(item.height);

  // Table write broadcast; the area is stored with the entry.
  always_comb begin
    load.we                = accept && (item.kind == KIND_LOAD);
    load.index             = item.entry_index;
    load.entry.width       = item.width;
    load.entry.height      = item.height;
    load.entry.pixel_bits  = item.pixel_bits;
    load.entry.refresh_hz  = item.refresh_hz;
    load.area              = item_area;
  end

  // Launch register in front of the first cell.
  always_comb begin
    launch_d                = '0;
    launch_d.valid          = accept_query;
    launch_d.kind           = item.kind;
    launch_d.cur.width      = item.width;
    launch_d.cur.height     = item.height;
    launch_d.cur.pixel_bits = item.pixel_bits;
    launch_d.cur.refresh_hz = item.refresh_hz;
    launch_d.cur_area       = item_area;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      launch_q <= '0;
    end else if (advance) begin
      launch_q <= launch_d;
    end
  end

  // The cell row.
  assign tok[0] = launch_q;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    dmfs_cell #(
      .CELL_INDEX (g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cfg_i     (cfg),
      .load_i    (load),
      .advance_i (advance),
      .tok_i     (tok[g]),
      .tok_o     (tok[g+1])
    );
  end

  // The row holds while a finished query waits for the result register.
  assign tail    = tok[TABLE_DEPTH];
  assign advance = !(tail.valid && out_valid_q && !out_o.ready);
  assign drain   = tail.valid && advance;

  always_comb begin
    busy_d = busy_q;
    if (accept_query) begin
      busy_d = 1'b1;
    end else if (drain) begin
      busy_d = 1'b0;
    end
  end

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (drain) begin
      out_valid_d          = 1'b1;
      out_d.found          = tail.found;
      out_d.new_width      = tail.best.width;
      out_d.new_height     = tail.best.height;
      out_d.new_pixel_bits = tail.best.pixel_bits;
      out_d.new_refresh_hz = tail.best.refresh_hz;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

endmodule

// File: rtl/dmfs_checker.sv
`include "display_mode_fallback_search_defines.svh"

module dmfs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_kind,
  input logic       out_valid,
  input logic       out_ready
);
  import dmfs_pkg::*;

  // A query transaction keeps the input closed while it walks the table.
  `DMFS_ASSERT_NEXT(a_query_blocks_input, clk_i, rst_ni, in_valid && in_ready && (in_kind != KIND_LOAD), !in_ready)

  // A load transaction taken with no result pending never makes a result.
  `DMFS_ASSERT_NEXT(a_load_no_result, clk_i, rst_ni, in_valid && in_ready && (in_kind == KIND_LOAD) && !out_valid, !out_valid)

  // A new result only follows a cycle in which a query was in progress.
  `DMFS_ASSERT_SAME(a_result_after_query, clk_i, rst_ni, $rose(out_valid), $past(!in_ready))

  // A result that is not taken stays offered.
  `DMFS_ASSERT_NEXT(a_result_holds, clk_i, rst_ni, out_valid && !out_ready, out_valid)

endmodule

bind display_mode_fallback_search dmfs_checker u_dmfs_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .in_kind   (in_i.payload.kind),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready)
);

// File: bench/display_mode_fallback_search_tb.sv
module display_mode_fallback_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dmfs_pkg::*;

  localparam logic [1:0]  REG_SPARE    = 2'd3;
  localparam int unsigned DEPTH        = DEFAULT_TABLE_DEPTH;
  localparam int unsigned DRAIN_CYCLES = DEPTH + 8;
  localparam int unsigned IDLE_LIMIT   = 3000;

  // Shadow of the mode table and registers, with the queue of search results still owed.
  class mode_search_scoreboard;
    mode_t            mode_tbl [DEPTH];
    logic [CFG_W-1:0] min_w;
    logic [CFG_W-1:0] min_h;
    logic [CFG_W-1:0] excl_w;
    out_item_t        owed_results [$];
    int               errors;
    int               loads;
    int               queries;
    int               hits;

    function new();
      foreach (mode_tbl[i]) mode_tbl[i] = '0;
      min_w   = RESET_MIN_WIDTH;
      min_h   = RESET_MIN_HEIGHT;
      excl_w  = RESET_EXCLUDED_WIDTH;
      errors  = 0;
      loads   = 0;
      queries = 0;
      hits    = 0;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) begin
        $display("ERROR at %0t: %s", $time, msg);
      end
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_MIN_WIDTH:      min_w  = value[CFG_W-1:0];
        REG_MIN_HEIGHT:     min_h  = value[CFG_W-1:0];
        REG_EXCLUDED_WIDTH: excl_w = value[CFG_W-1:0];
        default: ;
      endcase
    endfunction

    function void check_reg(logic [1:0] idx, logic [31:0] got);
      logic [31:0] want;
      case (idx)
        REG_MIN_WIDTH:      want = {16'd0, min_w};
        REG_MIN_HEIGHT:     want = {16'd0, min_h};
        default:            want = {16'd0, excl_w};
      endcase
      if (got !== want) begin
        report($sformatf("register %0d reads 0x%08h, expected 0x%08h", idx, got, want));
      end
    endfunction

    // Loads update the table; a query scans it and owes exactly one result.
    function void note_item(in_item_t it);
      out_item_t   best;
      mode_t       e;
      logic [31:0] cur_area;
      logic [31:0] ent_area;
      logic        same_res;
      if (it.kind == KIND_LOAD) begin
        mode_tbl[it.entry_index] = {it.width, it.height, it.pixel_bits, it.refresh_hz};
        loads++;
        return;
      end
      best     = '0;
      cur_area = 32'(it.width) * 32'(it.height);
      for (int i = 0; i < DEPTH; i++) begin
        e = mode_tbl[i];
        // A zero-width entry ends the scan.
        if (e.width == '0) break;
        if (e.pixel_bits != it.pixel_bits) continue;
        same_res = (e.width == it.width) && (e.height == it.height);
        ent_area = 32'(e.width) * 32'(e.height);
        case (it.kind)
          KIND_SMALLER_RES: begin
            if (e.width >= min_w && e.height >= min_h && e.width != excl_w &&
                ((e.width <= it.width && e.height < it.height) ||
                 (e.width < it.width && e.height <= it.height) || ent_area < cur_area) &&
                (!best.found || best.new_width < e.width ||
                 (best.new_width == e.width && best.new_height < e.height))) begin
              best = {1'b1, e};
            end
          end
          // A zero refresh never beats the cleared best, so it is never taken.
          KIND_LOWER_HZ: begin
            if (same_res && e.refresh_hz < it.refresh_hz &&
                best.new_refresh_hz < e.refresh_hz) begin
              best = {1'b1, e};
            end
          end
          default: begin
            if (same_res && e.refresh_hz > it.refresh_hz &&
                (!best.found || e.refresh_hz < best.new_refresh_hz)) begin
              best = {1'b1, e};
            end
          end
        endcase
      end
      queries++;
      if (best.found) hits++;
      owed_results.push_back(best);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (owed_results.size() == 0) begin
        report($sformatf("unexpected result %0d %0dx%0d %0d bpp %0d Hz", got.found,
                         got.new_width, got.new_height, got.new_pixel_bits, got.new_refresh_hz));
        return;
      end
      want = owed_results.pop_front();
      if (got.found !== want.found || got.new_width !== want.new_width ||
          got.new_height !== want.new_height || got.new_pixel_bits !== want.new_pixel_bits ||
          got.new_refresh_hz !== want.new_refresh_hz) begin
        report($sformatf({"result %0d %0dx%0d %0d bpp %0d Hz, ",
                          "expected %0d %0dx%0d %0d bpp %0d Hz"},
                         got.found, got.new_width, got.new_height, got.new_pixel_bits,
                         got.new_refresh_hz, want.found, want.new_width, want.new_height,
                         want.new_pixel_bits, want.new_refresh_hz));
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  dmfs_stream_if #(.payload_t(in_item_t))  in_if ();
  dmfs_stream_if #(.payload_t(out_item_t)) out_if ();

  mode_search_scoreboard sb;
  logic                  calm;
  int                    next_slot;
  int                    settings;
  int                    idle_cycles;

  display_mode_fallback_search u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly short gaps, a few long ones, none in a calm phase.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // A common display mode with a common depth and refresh.
  function automatic mode_t pool_mode();
    mode_t m;
    case ($urandom_range(0, 7))
      0: {m.width, m.height} = {16'd640, 16'd480};
      1: {m.width, m.height} = {16'd800, 16'd600};
      2: {m.width, m.height} = {16'd960, 16'd720};
      3: {m.width, m.height} = {16'd1024, 16'd768};
      4: {m.width, m.height} = {16'd1280, 16'd720};
      5: {m.width, m.height} = {16'd1280, 16'd1024};
      6: {m.width, m.height} = {16'd1600, 16'd900};
      default: {m.width, m.height} = {16'd1920, 16'd1080};
    endcase
    m.pixel_bits = 7'(8 * $urandom_range(1, 4));
    case ($urandom_range(0, 7))
      0: m.refresh_hz = 10'd0;
      1: m.refresh_hz = 10'd50;
      2: m.refresh_hz = 10'd60;
      3: m.refresh_hz = 10'd75;
      4: m.refresh_hz = 10'd85;
      5: m.refresh_hz = 10'd120;
      6: m.refresh_hz = 10'd144;
      default: m.refresh_hz = 10'd240;
    endcase
    return m;
  endfunction

  function automatic in_item_t mk(kind_e k, int idx, int w, int h, int b, int hz);
    in_item_t it;
    it.kind        = k;
    it.entry_index = 6'(idx);
    it.width       = 16'(w);
    it.height      = 16'(h);
    it.pixel_bits  = 7'(b);
    it.refresh_hz  = 10'(hz);
    return it;
  endfunction

  // Presents one transaction after a random gap and returns at the edge that takes it.
  task automatic send_item(in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= it;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drains the block, writes every register (and the unused slot), then reads them back.
  task automatic reconfigure(logic [15:0] mw, logic [15:0] mh, logic [15:0] ew);
    logic [31:0] rd;
    logic [31:0] value;
    in_if.valid <= 1'b0;
    // The wait on the clock lets the monitor note the last accepted transaction first.
    @(posedge clk_i);
    while (sb.owed_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    value = {16'($urandom), mw};
    apb_access(1'b1, REG_MIN_WIDTH, value, rd);
    sb.write_reg(REG_MIN_WIDTH, value);
    value = {16'($urandom), mh};
    apb_access(1'b1, REG_MIN_HEIGHT, value, rd);
    sb.write_reg(REG_MIN_HEIGHT, value);
    value = {16'($urandom), ew};
    apb_access(1'b1, REG_EXCLUDED_WIDTH, value, rd);
    sb.write_reg(REG_EXCLUDED_WIDTH, value);
    value = $urandom;
    apb_access(1'b1, REG_SPARE, value, rd);
    sb.write_reg(REG_SPARE, value);
    for (int i = 0; i < 3; i++) begin
      apb_access(1'b0, 2'(i), '0, rd);
      sb.check_reg(2'(i), rd);
    end
    settings++;
  endtask

  // Mostly contiguous table fills and queries built from table contents, with some noise.
  task automatic run_random(int n);
    in_item_t it;
    mode_t    m;
    int       pick;
    for (int i = 0; i < n; i++) begin
      // Halfway through, hold off until every search result has come back.
      if (i == n / 2) begin
        in_if.valid <= 1'b0;
        @(posedge clk_i);
        while (sb.owed_results.size() != 0) @(posedge clk_i);
      end
      pick           = $urandom_range(0, 99);
      it.entry_index = 6'($urandom);
      if (pick < 40) begin
        it.kind = KIND_LOAD;
        m = ($urandom_range(0, 99) < 75) ? pool_mode() : mode_t'(49'({$urandom, $urandom}));
        if ($urandom_range(0, 99) < 30) m.refresh_hz = 10'($urandom);
        if ($urandom_range(0, 99) < 10) m.pixel_bits = 7'($urandom_range(0, 64));
        if ($urandom_range(0, 99) < 4) m.width = '0;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          it.entry_index = 6'(next_slot);
          next_slot = (next_slot + 1) % DEPTH;
          if ($urandom_range(0, 99) < 3) next_slot = 0;
        end else if (pick < 75) begin
          it.entry_index = 6'($urandom_range(0, 7));
        end
      end else begin
        it.kind = kind_e'(2'($urandom_range(1, 3)));
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          m = sb.mode_tbl[$urandom_range(0, 15)];
        end else if (pick < 85) begin
          m = pool_mode();
        end else begin
          m = mode_t'(49'({$urandom, $urandom}));
        end
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
          m.refresh_hz = pool_mode().refresh_hz;
        end else if (pick < 60) begin
          m.refresh_hz = 10'($urandom);
        end
      end
      {it.width, it.height, it.pixel_bits, it.refresh_hz} = m;
      send_item(it);
    end
  endtask

  // Result receiver: bursts of ready separated by random stalls.
  initial begin
    int stall;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  end

  // Both channels are sampled at the clock edge on which each transaction completes.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) sb.note_item(in_if.payload);
      if (out_if.valid && out_if.ready) sb.check_result(out_if.payload);
    end
  end

  // Watchdog on cycles with no transaction on any port.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles, %0d results owed", idle_cycles,
               sb.owed_results.size());
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    sb            = new();
    calm          = 1'b0;
    next_slot     = 0;
    settings      = 1;
    idle_cycles   = 0;
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.payload = '0;
    out_if.ready  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part with the reset register values.
    send_item(mk(KIND_SMALLER_RES, 0, 1920, 1080, 32, 60));   // empty table
    send_item(mk(KIND_LOAD, 0, 1920, 1080, 32, 60));
    send_item(mk(KIND_LOAD, 1, 1920, 1080, 32, 75));
    send_item(mk(KIND_LOAD, 2, 1920, 1080, 32, 0));           // zero refresh
    send_item(mk(KIND_LOAD, 3, 1280, 1024, 32, 60));
    send_item(mk(KIND_LOAD, 4, 960, 720, 32, 60));            // excluded width
    send_item(mk(KIND_LOAD, 5, 1600, 900, 32, 60));
    send_item(mk(KIND_LOAD, 6, 1600, 900, 32, 85));           // tie with the entry before
    send_item(mk(KIND_LOAD, 7, 640, 480, 16, 60));
    send_item(mk(KIND_LOAD, 8, 1920, 1080, 32, 144));
    send_item(mk(KIND_LOAD, 9, 0, 0, 0, 0));                  // ends the scan
    send_item(mk(KIND_LOAD, 10, 1800, 1000, 32, 60));         // hidden behind the end
    send_item(mk(KIND_SMALLER_RES, 0, 1920, 1080, 32, 60));
    send_item(mk(KIND_LOWER_HZ, 0, 1920, 1080, 32, 75));
    send_item(mk(KIND_LOWER_HZ, 0, 1920, 1080, 32, 60));
    send_item(mk(KIND_HIGHER_HZ, 0, 1920, 1080, 32, 60));
    send_item(mk(KIND_HIGHER_HZ, 0, 1920, 1080, 32, 144));
    send_item(mk(KIND_SMALLER_RES, 63, 640, 480, 16, 1023));
    send_item(mk(KIND_LOAD, 63, 65535, 65535, 127, 1023));
    send_item(mk(KIND_HIGHER_HZ, 63, 65535, 65535, 127, 0));
    send_item(mk(KIND_LOAD, 9, 65535, 65535, 127, 1023));    // end marker removed
    send_item(mk(KIND_SMALLER_RES, 0, 65535, 65535, 32, 1023));
    send_item(mk(KIND_LOWER_HZ, 0, 65535, 65535, 127, 1023));
    send_item(mk(KIND_HIGHER_HZ, 0, 65535, 65535, 127, 1022));

    // Random phases, each under a different register setting.
    reconfigure(16'd0, 16'd0, 16'd0);
    run_random(190);
    reconfigure(16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(190);
    reconfigure(16'($urandom_range(0, 1280)), 16'($urandom_range(0, 1024)),
                pool_mode().width);
    calm = 1'b1;
    run_random(190);
    calm = 1'b0;
    reconfigure(16'd800, 16'd600, 16'd1280);
    run_random(190);
    reconfigure(16'($urandom), 16'($urandom), 16'($urandom));
    run_random(190);

    // Drain, then leave room for any stray result.
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.owed_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d table loads and %0d mode searches, %0d of which found a mode,",
             sb.loads, sb.queries, sb.hits);
    $display("under %0d register settings; %0d mismatches.", settings, sb.errors);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/dmfs_pkg.sv
rtl/dmfs_stream_if.sv
rtl/dmfs_cfg_regs.sv
rtl/dmfs_cell.sv
rtl/display_mode_fallback_search.sv
rtl/dmfs_checker.sv
bench/display_mode_fallback_search_tb.sv
